/* rtl/mft_pkg.sv */
// Shared widths, codes and memory port types for the max frequency tracker.
`default_nettype none

package mft_pkg;

    localparam int VALUE_W     = 10;
    localparam int COUNT_W     = 13;
    localparam int POP_W       = 11;
    localparam int POP_AW      = 12;
    localparam int COUNT_LIMIT = 4096;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic               we;
        logic [VALUE_W-1:0] waddr;
        logic [COUNT_W-1:0] wdata;
        logic [VALUE_W-1:0] raddr;
    } vc_port_t;

    typedef struct packed {
        logic              we;
        logic [POP_AW-1:0] waddr;
        logic [POP_W-1:0]  wdata;
        logic [POP_AW-1:0] raddr_a;
        logic [POP_AW-1:0] raddr_b;
    } pop_port_t;

endpackage

`default_nettype wire

/* rtl/mft_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module mft_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 13
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/mft_ctrl.sv */
// Sequencer: clearing pass, count and population read-modify-write, result register.
`default_nettype none

module mft_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [mft_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [mft_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                  m_tuser,
    output mft_pkg::vc_port_t                     vc_port,
    input  wire logic [mft_pkg::COUNT_W-1:0]      vc_rdata,
    output mft_pkg::pop_port_t                    pop_port,
    input  wire logic [mft_pkg::POP_W-1:0]        pop_rdata_a,
    input  wire logic [mft_pkg::POP_W-1:0]        pop_rdata_b
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CNT  = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [mft_pkg::COUNT_W-1:0] CNT_ONE   = mft_pkg::COUNT_W'(1);
    localparam logic [mft_pkg::COUNT_W-1:0] CNT_TWO   = mft_pkg::COUNT_W'(2);
    localparam logic [mft_pkg::COUNT_W-1:0] CNT_LIMIT =
        mft_pkg::COUNT_W'(mft_pkg::COUNT_LIMIT);
    localparam logic [mft_pkg::POP_W-1:0]   POP_ONE   = mft_pkg::POP_W'(1);

    logic [2:0]                      state_reg, state_next;
    logic [mft_pkg::POP_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                            kind_reg, kind_next;
    logic [mft_pkg::VALUE_W-1:0]     value_reg, value_next;
    logic [mft_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [mft_pkg::COUNT_W-1:0]     top_reg, top_next;
    logic                            rej_reg, rej_next;
    logic                            upd_reg, upd_next;
    logic [mft_pkg::POP_W-1:0]       popb_reg, popb_next;
    logic                            m_valid_reg, m_valid_next;
    logic [mft_pkg::COUNT_W-1:0]     m_count_reg, m_count_next;
    logic                            m_rej_reg, m_rej_next;

    logic [mft_pkg::COUNT_W-1:0]     c_dec, c_dec2, c_inc;
    logic [mft_pkg::COUNT_W-1:0]     r_dec, r_dec2, r_inc, new_k;
    logic [mft_pkg::POP_W-1:0]       pa_dec;
    logic                            rej_now;
    logic                            out_free;

    assign c_dec  = vc_rdata - CNT_ONE;
    assign c_dec2 = vc_rdata - CNT_TWO;
    assign c_inc  = vc_rdata + CNT_ONE;
    assign r_dec  = cnt_reg - CNT_ONE;
    assign r_dec2 = cnt_reg - CNT_TWO;
    assign r_inc  = cnt_reg + CNT_ONE;
    assign new_k  = (kind_reg == mft_pkg::KIND_REMOVE) ? r_dec : r_inc;
    assign pa_dec = (pop_rdata_a != '0) ? (pop_rdata_a - POP_ONE) : pop_rdata_a;
    assign rej_now = (value_reg != '0) &&
                     (((kind_reg == mft_pkg::KIND_REMOVE) && (vc_rdata == '0)) ||
                      ((kind_reg == mft_pkg::KIND_ADD) && (vc_rdata >= CNT_LIMIT)));
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mft_pkg::M_TDATA_W'(m_count_reg);
    assign m_tuser  = m_rej_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        cnt_next     = cnt_reg;
        top_next     = top_reg;
        rej_next     = rej_reg;
        upd_next     = upd_reg;
        popb_next    = popb_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        m_rej_next   = m_rej_reg;
        vc_port      = '0;
        pop_port     = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR: begin
                vc_port.we     = (clr_cnt_reg[mft_pkg::POP_AW-1:mft_pkg::VALUE_W] == '0);
                vc_port.waddr  = clr_cnt_reg[mft_pkg::VALUE_W-1:0];
                pop_port.we    = 1'b1;
                pop_port.waddr = clr_cnt_reg;
                clr_cnt_next   = clr_cnt_reg + mft_pkg::POP_AW'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                vc_port.raddr = s_tdata[mft_pkg::VALUE_W-1:0];
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    value_next = s_tdata[mft_pkg::VALUE_W-1:0];
                    state_next = ST_CNT;
                end
            end
            ST_CNT: begin
                rej_next = rej_now;
                cnt_next = vc_rdata;
                if ((value_reg == '0) || rej_now) begin
                    upd_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    upd_next          = 1'b1;
                    vc_port.we        = 1'b1;
                    vc_port.waddr     = value_reg;
                    vc_port.wdata     = (kind_reg == mft_pkg::KIND_REMOVE) ? c_dec : c_inc;
                    pop_port.raddr_a  = c_dec[mft_pkg::POP_AW-1:0];
                    pop_port.raddr_b  = (kind_reg == mft_pkg::KIND_REMOVE) ?
                                        c_dec2[mft_pkg::POP_AW-1:0] :
                                        vc_rdata[mft_pkg::POP_AW-1:0];
                    state_next        = ST_POP;
                end
            end
            ST_POP: begin
                pop_port.we    = (cnt_reg != '0);
                pop_port.waddr = r_dec[mft_pkg::POP_AW-1:0];
                pop_port.wdata = pa_dec;
                popb_next      = pop_rdata_b + POP_ONE;
                if (kind_reg == mft_pkg::KIND_REMOVE) begin
                    if ((pa_dec == '0) && (top_reg == cnt_reg)) begin
                        top_next = r_dec;
                    end
                end else if (r_inc > top_reg) begin
                    top_next = r_inc;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                pop_port.we    = upd_reg && (new_k != '0);
                pop_port.waddr = (kind_reg == mft_pkg::KIND_REMOVE) ?
                                 r_dec2[mft_pkg::POP_AW-1:0] :
                                 cnt_reg[mft_pkg::POP_AW-1:0];
                pop_port.wdata = popb_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = top_reg;
                    m_rej_next   = rej_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        cnt_reg     <= cnt_next;
        rej_reg     <= rej_next;
        upd_reg     <= upd_next;
        popb_reg    <= popb_next;
        m_count_reg <= m_count_next;
        m_rej_reg   <= m_rej_next;
    end

endmodule

`default_nettype wire

/* rtl/max_frequency_tracker_top.sv */
// Top level of the max frequency tracker: sequencer plus count and population memories.
//
// The block keeps a multiset of value identifiers. Each input transfer carries
// the value in s_tdata and the operation in s_tuser (0 adds one occurrence,
// 1 removes one). Value 0 changes nothing. Every input transfer yields exactly
// one output transfer: m_tdata carries the greatest occurrence count present
// after the item, and m_tuser is set when a remove of an absent value or an
// add at the count limit of 4096 was ignored.
// An item passes through these steps in order: accept and count read, count
// write with two population reads, population decrement, population increment
// with the result load. A new item is taken only once the last step is done,
// as the count memory and then the population memory go through a dependent
// read-modify-write. After reset a clearing pass zeroes both memories while
// s_tready stays low. The output register holds a finished result while the
// receiver stalls; the next item is accepted and worked on meanwhile, and it
// waits in its last step until the output register is free.
`default_nettype none

module max_frequency_tracker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // value [9:0], zero [15:10]
    input  wire logic [0:0]  s_tuser,   // kind [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // max_count [12:0], zero [15:13]
    output logic      [0:0]  m_tuser    // rejected [0]
);

    mft_pkg::vc_port_t                vc_port;
    mft_pkg::pop_port_t               pop_port;
    logic [mft_pkg::COUNT_W-1:0]      vc_rdata;
    logic [mft_pkg::POP_W-1:0]        pop_rdata_a;
    logic [mft_pkg::POP_W-1:0]        pop_rdata_b;

    mft_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser[0]),
        .vc_port     (vc_port),
        .vc_rdata    (vc_rdata),
        .pop_port    (pop_port),
        .pop_rdata_a (pop_rdata_a),
        .pop_rdata_b (pop_rdata_b)
    );

    mft_ram #(
        .ADDR_W (mft_pkg::VALUE_W),
        .DATA_W (mft_pkg::COUNT_W)
    ) u_vc_ram (
        .aclk  (aclk),
        .we    (vc_port.we),
        .waddr (vc_port.waddr),
        .wdata (vc_port.wdata),
        .raddr (vc_port.raddr),
        .rdata (vc_rdata)
    );

    mft_ram #(
        .ADDR_W (mft_pkg::POP_AW),
        .DATA_W (mft_pkg::POP_W)
    ) u_pop_ram_a (
        .aclk  (aclk),
        .we    (pop_port.we),
        .waddr (pop_port.waddr),
        .wdata (pop_port.wdata),
        .raddr (pop_port.raddr_a),
        .rdata (pop_rdata_a)
    );

    mft_ram #(
        .ADDR_W (mft_pkg::POP_AW),
        .DATA_W (mft_pkg::POP_W)
    ) u_pop_ram_b (
        .aclk  (aclk),
        .we    (pop_port.we),
        .waddr (pop_port.waddr),
        .wdata (pop_port.wdata),
        .raddr (pop_port.raddr_b),
        .rdata (pop_rdata_b)
    );

endmodule

`default_nettype wire

/* tb/max_frequency_tracker_top_tb.sv */
// Self-checking testbench for the max frequency tracker with a directed table and random traffic.
`default_nettype none

module max_frequency_tracker_top_tb;
    import mft_pkg::*;

    localparam int VALUE_SLOTS = 1 << VALUE_W;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 550;
    localparam int ROWS = 21;

    typedef struct packed {
        logic [COUNT_W-1:0] max_count;
        logic               rejected;
    } mode_result_t;

    typedef struct {
        logic               op;
        logic [VALUE_W-1:0] val;
        int                 reps;
        bit                 typed;
        logic [COUNT_W-1:0] max_count;
        logic               rejected;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    logic [COUNT_W-1:0] freq_of [VALUE_SLOTS];
    logic [POP_W-1:0]   holders [0:COUNT_LIMIT];
    logic [COUNT_W-1:0] peak;

    mode_result_t awaited_modes [$];
    plan_row_t    plan [ROWS];
    int           errors = 0;
    int           stall_cycles = 0;
    bit           src_idle = 1'b1;
    bit           snk_idle = 1'b1;

    max_frequency_tracker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic mode_result_t track_frequency(logic op, logic [VALUE_W-1:0] val);
        mode_result_t       r;
        logic [COUNT_W-1:0] c;
        r.rejected = 1'b0;
        if (val != '0) begin
            c = freq_of[val];
            if (op == KIND_REMOVE) begin
                if (c == '0) begin
                    r.rejected = 1'b1;
                end else begin
                    if (holders[c] != '0) holders[c] = holders[c] - 1'b1;
                    if (holders[c] == '0 && peak == c) peak = c - 1'b1;
                    freq_of[val] = c - 1'b1;
                    if (c != 13'd1) holders[c - 1'b1] = holders[c - 1'b1] + 1'b1;
                end
            end else begin
                if (c >= COUNT_LIMIT) begin
                    r.rejected = 1'b1;
                end else begin
                    if (c != '0 && holders[c] != '0) holders[c] = holders[c] - 1'b1;
                    freq_of[val] = c + 1'b1;
                    holders[c + 1'b1] = holders[c + 1'b1] + 1'b1;
                    if (c + 1'b1 > peak) peak = c + 1'b1;
                end
            end
        end
        r.max_count = peak;
        return r;
    endfunction

    function automatic void queue_result(mode_result_t r);
        awaited_modes.insert(awaited_modes.size(), r);
    endfunction

    task automatic send_item(input logic op, input logic [VALUE_W-1:0] val,
                             output mode_result_t predicted);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-VALUE_W){1'b0}}, val};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = track_frequency(op, val);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_modes.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int           gap;
        int           seen;
        mode_result_t want;
        seen = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (seen % 40 == 0) snk_idle = ($urandom_range(0, 3) != 0);
            gap = snk_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            seen++;
            if (awaited_modes.size() == 0) begin
                $error("max_count: no result expected, actual %0d", m_tdata[COUNT_W-1:0]);
                errors++;
            end else begin
                want = awaited_modes.pop_front();
                if (m_tdata[COUNT_W-1:0] !== want.max_count) begin
                    $error("max_count: expected %0d, actual %0d",
                           want.max_count, m_tdata[COUNT_W-1:0]);
                    errors++;
                end
                if (m_tuser[0] !== want.rejected) begin
                    $error("rejected: expected %0d, actual %0d", want.rejected, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[M_TDATA_W-1:COUNT_W] !== '0) begin
                    $error("m_tdata padding: expected 0, actual %0h",
                           m_tdata[M_TDATA_W-1:COUNT_W]);
                    errors++;
                end
            end
        end
    end

    initial begin
        mode_result_t       guess;
        mode_result_t       want;
        logic [VALUE_W-1:0] pool [8];
        logic [VALUE_W-1:0] val;
        logic               op;
        int                 roll;

        foreach (freq_of[i]) freq_of[i] = '0;
        foreach (holders[i]) holders[i] = '0;
        peak = '0;

        plan = '{
            '{KIND_REMOVE, 10'd5,    1,    1'b1, 13'd0,    1'b1},
            '{KIND_ADD,    10'd0,    1,    1'b1, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd0,    1,    1'b1, 13'd0,    1'b0},
            '{KIND_ADD,    10'd1023, 1,    1'b1, 13'd1,    1'b0},
            '{KIND_ADD,    10'd1,    1,    1'b0, 13'd0,    1'b0},
            '{KIND_ADD,    10'd1023, 1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd1,    1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd1023, 1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd1023, 1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd1023, 1,    1'b1, 13'd0,    1'b1},
            '{KIND_ADD,    10'd682,  1,    1'b0, 13'd0,    1'b0},
            '{KIND_ADD,    10'd341,  1,    1'b0, 13'd0,    1'b0},
            '{KIND_ADD,    10'd682,  1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd341,  1,    1'b0, 13'd0,    1'b0},
            '{KIND_ADD,    10'd700,  64,   1'b0, 13'd0,    1'b0},
            '{KIND_ADD,    10'd700,  1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd700,  65,   1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd682,  2,    1'b0, 13'd0,    1'b0},
            '{KIND_ADD,    10'd512,  2,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd512,  1,    1'b0, 13'd0,    1'b0},
            '{KIND_REMOVE, 10'd0,    1,    1'b0, 13'd0,    1'b0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (i == 14) src_idle = 1'b0;
            if (i == 17) src_idle = 1'b1;
            for (int r = 0; r < plan[i].reps; r++) begin
                send_item(plan[i].op, plan[i].val, guess);
                if (plan[i].typed) begin
                    want.max_count = plan[i].max_count;
                    want.rejected  = plan[i].rejected;
                end else begin
                    want = guess;
                end
                queue_result(want);
            end
        end

        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                src_idle = ($urandom_range(0, 3) != 0);
                foreach (pool[i]) pool[i] = VALUE_W'($urandom_range(1, VALUE_SLOTS - 1));
            end
            if (n % 100 == 50 && $urandom_range(0, 1) == 1) hold_until_drained();
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                val = pool[$urandom_range(0, 7)];
                op  = ($urandom_range(0, 99) < 60) ? KIND_ADD : KIND_REMOVE;
            end else if (roll < 95) begin
                val = VALUE_W'($urandom_range(0, VALUE_SLOTS - 1));
                op  = 1'($urandom_range(0, 1));
            end else begin
                val = '0;
                op  = 1'($urandom_range(0, 1));
            end
            send_item(op, val, guess);
            queue_result(guess);
        end

        hold_until_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/mft_pkg.sv
rtl/mft_ram.sv
rtl/mft_ctrl.sv
rtl/max_frequency_tracker_top.sv
tb/max_frequency_tracker_top_tb.sv
